FILE: hdl/b64enc_pkg.sv
// Shared types, constants and the alphabet mapping for the base64 stream encoder.
package b64enc_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int CHARS_PER_JOB       = 4;

  localparam logic [7:0] PAD_CHAR     = 8'h3D;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       stream_last;
  } out_word_t;

  // One input byte's worth of characters, oldest in chars[0].
  typedef struct packed {
    logic [CHARS_PER_JOB-1:0][7:0] chars;
    logic [1:0]                    last_idx;
    logic                          fin;
  } job_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = CHAR_UPPER_A + {2'b00, v};
    end else if (v < 6'd52) begin
      c = CHAR_LOWER_A + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = CHAR_ZERO + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

endpackage

FILE: hdl/b64enc_front.sv
// Front end: takes input bytes, tracks the group position and builds character jobs.
module b64enc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  b64enc_pkg::in_word_t in_word,
  output b64enc_pkg::job_t   job
);

  localparam logic [1:0] PH_ZERO = 2'd0;
  localparam logic [1:0] PH_ONE  = 2'd1;
  localparam logic [1:0] PH_TWO  = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] pending_r, pending_nxt;
  logic [7:0] b;

  assign b = in_word.data_byte;

  always_comb begin
    job.chars    = {b64enc_pkg::CHARS_PER_JOB{b64enc_pkg::PAD_CHAR}};
    job.last_idx = 2'd0;
    job.fin      = in_word.final_byte;
    phase_nxt    = PH_ZERO;
    pending_nxt  = 4'd0;
    case (phase_r)
      PH_ONE: begin
        job.chars[0] = b64enc_pkg::sextet_char({pending_r[1:0], b[7:4]});
        pending_nxt  = b[3:0];
        phase_nxt    = PH_TWO;
        if (in_word.final_byte) begin
          job.chars[1] = b64enc_pkg::sextet_char({b[3:0], 2'b00});
          job.last_idx = 2'd2;
        end
      end
      PH_TWO: begin
        job.chars[0] = b64enc_pkg::sextet_char({pending_r[3:0], b[7:6]});
        job.chars[1] = b64enc_pkg::sextet_char(b[5:0]);
        job.last_idx = 2'd1;
      end
      default: begin
        job.chars[0] = b64enc_pkg::sextet_char(b[7:2]);
        pending_nxt  = {2'b00, b[1:0]};
        phase_nxt    = PH_ONE;
        if (in_word.final_byte) begin
          job.chars[1] = b64enc_pkg::sextet_char({b[1:0], 4'b0000});
          job.last_idx = 2'd3;
        end
      end
    endcase
    // the end of a message starts the next one from a clean group
    if (in_word.final_byte) begin
      phase_nxt   = PH_ZERO;
      pending_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_ZERO;
      pending_r <= 4'd0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      pending_r <= pending_nxt;
    end
  end

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_word.final_byte |=> phase_r == PH_ZERO && pending_r == 4'd0)
    else $error("state not cleared after final byte");

  a_group_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_word.final_byte && phase_r == PH_ZERO |=> phase_r == PH_ONE)
    else $error("phase did not advance from group start");

  a_fin_length: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_word.final_byte && phase_r != PH_TWO |-> job.last_idx != 2'd1)
    else $error("padded tail has wrong length");

endmodule

FILE: hdl/b64enc_queue.sv
// Short job queue between the front end and the character emitter.
module b64enc_queue #(
  parameter int DEPTH = b64enc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  b64enc_pkg::job_t wdata,
  output logic             full,
  input  logic             pop,
  output b64enc_pkg::job_t rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b64enc_pkg::job_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow push");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> wr_ptr_r == rd_ptr_r)
    else $error("pointers differ on empty queue");

endmodule

FILE: hdl/b64enc_back.sv
// Back end: walks each queued job and hands out one character per word.
module b64enc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  b64enc_pkg::job_t      job,
  input  logic                  job_empty,
  output logic                  job_pop,
  output b64enc_pkg::out_word_t out_word,
  output logic                  out_valid,
  input  logic                  out_pop
);

  logic [1:0]            idx_r;
  logic                  out_valid_r;
  b64enc_pkg::out_word_t out_r;
  logic                  load, take, at_last;

  assign load      = !out_valid_r || out_pop;
  assign take      = load && !job_empty;
  assign at_last   = (idx_r == job.last_idx);
  assign job_pop   = take && at_last;
  assign out_word  = out_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (take) begin
      out_r.out_char    <= job.chars[idx_r];
      out_r.run_last    <= at_last;
      out_r.stream_last <= at_last && job.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= !job_empty;
      if (take) begin
        // advance within the job, restart on the next one
        idx_r <= at_last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  a_stream_implies_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.stream_last |-> out_r.run_last)
    else $error("stream end without run end");

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    !job_empty |-> idx_r <= job.last_idx)
    else $error("character index past end of job");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_empty |-> idx_r == 2'd0)
    else $error("index left mid-job with queue empty");

endmodule

FILE: hdl/base64_stream_encoder.sv
// Base64 stream encoder (standard alphabet, '=' padded): one byte in, one to four
// characters out. A byte is accepted in any cycle while the job queue has room,
// and the output side delivers one character per cycle while the consumer pops each
// character, so the character stage sets the sustained rate of the encoder. The first
// character of a byte passes through the job queue and then the output register before
// it appears on the output.
module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  b64enc_pkg::in_word_t  in_data,
  output logic                  out_empty,
  input  logic                  out_pop,
  output b64enc_pkg::out_word_t out_data
);

  b64enc_pkg::job_t front_job, head_job;
  logic             q_full, q_empty, q_pop, in_accept, out_valid;

  assign in_full   = q_full;
  assign in_accept = in_push && !q_full;
  assign out_empty = !out_valid;

  b64enc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .in_word (in_data),
    .job     (front_job)
  );

  b64enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_accept),
    .wdata (front_job),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (head_job),
    .empty (q_empty)
  );

  b64enc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (head_job),
    .job_empty (q_empty),
    .job_pop   (q_pop),
    .out_word  (out_data),
    .out_valid (out_valid),
    .out_pop   (out_pop)
  );

endmodule
